@@ rtl/core/assert_macros.svh @@
// assertion macros for the rtl in this folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/ted_pkg.sv @@
// types, constants and helper functions of the text encoding detector
`timescale 1ns / 1ps

package ted_pkg;

  typedef enum logic [2:0] {
    ENC_UNSET   = 3'd0,
    ENC_UTF16LE = 3'd1,
    ENC_UTF16BE = 3'd2,
    ENC_UTF8    = 3'd3,
    ENC_JIS     = 3'd4,
    ENC_ASCII   = 3'd5,
    ENC_SJIS    = 3'd6,
    ENC_EUCJP   = 3'd7
  } enc_t;

  typedef enum logic [1:0] {
    WIDE_NONE = 2'd0,
    WIDE_LE   = 2'd1,
    WIDE_BE   = 2'd2
  } wide_t;

  localparam int SCORE_W = 18;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  typedef logic [SCORE_W-1:0] score_t;

  // history of earlier bytes, newest first; the longest escape needs five
  localparam int HIST_DEPTH = 5;
  localparam int WIN_DEPTH  = HIST_DEPTH + 1;
  localparam logic [2:0] IDX_MAX = 3'd7;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] EUC_SS2 = 8'h8E;
  localparam logic [7:0] EUC_SS3 = 8'h8F;

  // iso-2022-jp escapes: length, then bytes oldest first
  localparam int NUM_ESC = 7;
  localparam logic [2:0] ESC_LEN [NUM_ESC] = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd6, 3'd4};
  localparam logic [7:0] ESC_SEQ [NUM_ESC][WIN_DEPTH] = '{
    '{8'h1B, 8'h28, 8'h42, 8'h00, 8'h00, 8'h00},
    '{8'h1B, 8'h28, 8'h4A, 8'h00, 8'h00, 8'h00},
    '{8'h1B, 8'h28, 8'h49, 8'h00, 8'h00, 8'h00},
    '{8'h1B, 8'h24, 8'h40, 8'h00, 8'h00, 8'h00},
    '{8'h1B, 8'h24, 8'h42, 8'h00, 8'h00, 8'h00},
    '{8'h1B, 8'h26, 8'h40, 8'h1B, 8'h24, 8'h42},
    '{8'h1B, 8'h24, 8'h28, 8'h44, 8'h00, 8'h00}
  };

  // byte-order marks: bit0 ff fe, bit1 fe ff, bit2 ef bb bf
  localparam int NUM_BOM = 3;
  localparam logic [2:0] BOM_LEN [NUM_BOM] = '{3'd2, 3'd2, 3'd3};
  localparam logic [7:0] BOM_SEQ [NUM_BOM][4] = '{
    '{8'hFF, 8'hFE, 8'h00, 8'h00},
    '{8'hFE, 8'hFF, 8'h00, 8'h00},
    '{8'hEF, 8'hBB, 8'hBF, 8'h00}
  };

  // everything the verdict needs, captured on the final byte
  typedef struct packed {
    logic   bom_le;
    logic   bom_be;
    logic   bom_u8;
    logic   jis;
    wide_t  wide;
    logic   non_ascii;
    score_t sjis_score;
    score_t utf8_score;
    score_t euc_score;
  } fin_t;

  function automatic logic in_rng(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // window is newest first; pos is the index of the newest byte
  function automatic logic esc_match(logic [WIN_DEPTH-1:0][7:0] win, logic [2:0] pos);
    logic any;
    logic hit;
    any = 1'b0;
    for (int e = 0; e < NUM_ESC; e++) begin
      hit = ({1'b0, pos} + 4'd1) >= {1'b0, ESC_LEN[e]};
      for (int k = 0; k < WIN_DEPTH; k++) begin
        if (k < int'(ESC_LEN[e]) && win[int'(ESC_LEN[e]) - 1 - k] != ESC_SEQ[e][k]) begin
          hit = 1'b0;
        end
      end
      any = any | hit;
    end
    return any;
  endfunction

  function automatic score_t sat_add(score_t s, logic [2:0] inc);
    logic [SCORE_W:0] sum;
    sum = {1'b0, s} + {{(SCORE_W-2){1'b0}}, inc};
    return sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
  endfunction

endpackage

@@ rtl/core/ted_ifs.sv @@
// valid/ready channel interfaces for byte input and verdict output
`timescale 1ns / 1ps

interface ted_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ted_out_if;
  import ted_pkg::*;
  logic valid;
  logic ready;
  enc_t encoding;

  modport source (output valid, output encoding, input ready);
  modport sink   (input valid, input encoding, output ready);
endinterface

@@ rtl/core/text_encoding_detector_core.sv @@
// text encoding detector: byte stream in, one encoding verdict per buffer out
//
//   channel  dir  payload               transaction
//   in_ch    in   data_byte, last_byte  one byte of the buffer
//   out_ch   out  encoding              one verdict, after the final byte
//
// throughput is one byte per cycle while the input does not stall; every test is a small window compare or
// a saturating score add done in the cycle the byte is taken
// the final byte's results are registered in the capture stage, and the three score
// compares are made as the verdict moves on from there into the output register
// reset (synchronous, rst_n low) clears all detector state and both stages
// the input stalls only while the capture stage holds a verdict that cannot
// move because the output register is full and out_ch.ready is low
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_encoding_detector_core (
  input  logic         clk,
  input  logic         rst_n,
  ted_in_if.sink       in_ch,
  ted_out_if.source    out_ch
);
  import ted_pkg::*;

  // detector state
  logic [HIST_DEPTH-1:0][7:0] hist_r, hist_nxt;       // earlier bytes, newest first
  logic [2:0]   byte_idx_r, byte_idx_nxt;              // saturates at seven
  logic         parity_r, parity_nxt;
  logic [2:0]   bom_r, bom_nxt;                        // surviving mark candidates
  logic         high_r, high_nxt;                      // byte above 0x7f seen
  logic         non_ascii_r, non_ascii_nxt;
  logic         esc_pend_r, esc_pend_nxt;              // window ends a jis escape
  logic         jis_r, jis_nxt;
  wide_t        wide_r, wide_nxt;
  logic         sjis_skip_r, sjis_skip_nxt;
  logic         utf8_skip_r, utf8_skip_nxt;
  logic [1:0]   euc_skip_r, euc_skip_nxt;
  score_t       sjis_score_r, sjis_score_nxt;
  score_t       utf8_score_r, utf8_score_nxt;
  score_t       euc_score_r, euc_score_nxt;

  // capture stage and output register
  logic  fin_valid_r, fin_valid_nxt;
  fin_t  fin_r, fin_nxt;
  logic  out_valid_r, out_valid_nxt;
  enc_t  out_enc_r, out_enc_nxt;

  logic  in_acc;
  logic  fin_move;

  // state after this byte, before the end-of-buffer clear
  logic [2:0] bom_upd;
  logic       jis_upd;
  wide_t      wide_upd;
  logic       high_upd;
  logic       non_ascii_upd;
  logic       esc_pend_upd;
  logic       sjis_skip_upd;
  logic       utf8_skip_upd;
  logic [1:0] euc_skip_upd;
  score_t     sjis_score_upd;
  score_t     utf8_score_upd;
  score_t     euc_score_upd;

  // handshake: the capture stage moves when the output register is free or being read
  assign fin_move     = fin_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !fin_valid_r || fin_move;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.encoding = out_enc_r;

  // per-byte tests
  always_comb begin
    logic [7:0] b;
    logic [7:0] prev1;
    logic [7:0] prev2;
    logic [2:0] p;
    logic [2:0] u_inc;
    logic [2:0] e_inc;
    logic [2:0] s_inc;
    logic [WIN_DEPTH-1:0][7:0] win;

    b     = in_ch.data_byte;
    p     = byte_idx_r;
    prev1 = hist_r[0];
    prev2 = hist_r[1];

    // a mark survives only while every byte so far matches it
    bom_upd = bom_r;
    for (int k = 0; k < NUM_BOM; k++) begin
      if (p < BOM_LEN[k] && b != BOM_SEQ[k][p[1:0]]) begin
        bom_upd[k] = 1'b0;
      end
    end

    // an escape counts once any byte follows it
    jis_upd = jis_r || esc_pend_r;

    // first zero byte followed by a seven-bit byte decides the utf-16 order
    wide_upd = wide_r;
    if (p != 3'd0 && wide_r == WIDE_NONE && prev1 == 8'h00 && !b[7]) begin
      wide_upd = parity_r ? WIDE_BE : WIDE_LE;
    end

    high_upd      = high_r || b[7];
    non_ascii_upd = non_ascii_r || b[7] || (b == CH_ESC);

    // shift-jis pair scorer
    s_inc         = 3'd0;
    sjis_skip_upd = sjis_skip_r;
    if (p != 3'd0) begin
      if (sjis_skip_r) begin
        sjis_skip_upd = 1'b0;
      end else if ((in_rng(prev1, 8'h81, 8'h9F) || in_rng(prev1, 8'hE0, 8'hFC)) &&
                   (in_rng(b, 8'h40, 8'h7E) || in_rng(b, 8'h80, 8'hFC))) begin
        s_inc         = 3'd2;
        sjis_skip_upd = 1'b1;
      end
    end

    // utf-8 and euc-jp: pairs and three-byte starts at prev2, then the tail pair on the final byte
    // a three-byte utf-8 hit skips only one start position
    u_inc         = 3'd0;
    utf8_skip_upd = utf8_skip_r;
    e_inc         = 3'd0;
    euc_skip_upd  = euc_skip_r;
    if (p >= 3'd2) begin
      if (utf8_skip_upd) begin
        utf8_skip_upd = 1'b0;
      end else if (in_rng(prev2, 8'hC0, 8'hDF) && in_rng(prev1, 8'h80, 8'hBF)) begin
        u_inc         = u_inc + 3'd2;
        utf8_skip_upd = 1'b1;
      end else if (in_rng(prev2, 8'hE0, 8'hEF) && in_rng(prev1, 8'h80, 8'hBF) &&
                   in_rng(b, 8'h80, 8'hBF)) begin
        u_inc         = u_inc + 3'd3;
        utf8_skip_upd = 1'b1;
      end

      if (euc_skip_upd != 2'd0) begin
        euc_skip_upd = euc_skip_upd - 2'd1;
      end else if ((in_rng(prev2, 8'hA1, 8'hFE) && in_rng(prev1, 8'hA1, 8'hFE)) ||
                   (prev2 == EUC_SS2 && in_rng(prev1, 8'hA1, 8'hDF))) begin
        e_inc        = e_inc + 3'd2;
        euc_skip_upd = 2'd1;
      end else if (prev2 == EUC_SS3 && in_rng(prev1, 8'hA1, 8'hFE) &&
                   in_rng(b, 8'hA1, 8'hFE)) begin
        e_inc        = e_inc + 3'd3;
        euc_skip_upd = 2'd2;
      end
    end
    if (in_ch.last_byte && p != 3'd0) begin
      if (utf8_skip_upd) begin
        utf8_skip_upd = 1'b0;
      end else if (in_rng(prev1, 8'hC0, 8'hDF) && in_rng(b, 8'h80, 8'hBF)) begin
        u_inc         = u_inc + 3'd2;
        utf8_skip_upd = 1'b1;
      end

      if (euc_skip_upd != 2'd0) begin
        euc_skip_upd = euc_skip_upd - 2'd1;
      end else if ((in_rng(prev1, 8'hA1, 8'hFE) && in_rng(b, 8'hA1, 8'hFE)) ||
                   (prev1 == EUC_SS2 && in_rng(b, 8'hA1, 8'hDF))) begin
        e_inc        = e_inc + 3'd2;
        euc_skip_upd = 2'd1;
      end
    end

    sjis_score_upd = sat_add(sjis_score_r, s_inc);
    utf8_score_upd = sat_add(utf8_score_r, u_inc);
    euc_score_upd  = sat_add(euc_score_r, e_inc);

    // escape window including this byte; blocked once a high byte showed up
    win          = {hist_r, b};
    esc_pend_upd = !high_upd && esc_match(win, p);
  end

  // next state: the final byte returns the detector to its reset state
  always_comb begin
    hist_nxt       = hist_r;
    byte_idx_nxt   = byte_idx_r;
    parity_nxt     = parity_r;
    bom_nxt        = bom_r;
    high_nxt       = high_r;
    non_ascii_nxt  = non_ascii_r;
    esc_pend_nxt   = esc_pend_r;
    jis_nxt        = jis_r;
    wide_nxt       = wide_r;
    sjis_skip_nxt  = sjis_skip_r;
    utf8_skip_nxt  = utf8_skip_r;
    euc_skip_nxt   = euc_skip_r;
    sjis_score_nxt = sjis_score_r;
    utf8_score_nxt = utf8_score_r;
    euc_score_nxt  = euc_score_r;

    if (in_acc && in_ch.last_byte) begin
      hist_nxt       = '0;
      byte_idx_nxt   = 3'd0;
      parity_nxt     = 1'b0;
      bom_nxt        = 3'b111;
      high_nxt       = 1'b0;
      non_ascii_nxt  = 1'b0;
      esc_pend_nxt   = 1'b0;
      jis_nxt        = 1'b0;
      wide_nxt       = WIDE_NONE;
      sjis_skip_nxt  = 1'b0;
      utf8_skip_nxt  = 1'b0;
      euc_skip_nxt   = 2'd0;
      sjis_score_nxt = '0;
      utf8_score_nxt = '0;
      euc_score_nxt  = '0;
    end else if (in_acc) begin
      hist_nxt       = {hist_r[HIST_DEPTH-2:0], in_ch.data_byte};
      byte_idx_nxt   = (byte_idx_r == IDX_MAX) ? IDX_MAX : byte_idx_r + 3'd1;
      parity_nxt     = !parity_r;
      bom_nxt        = bom_upd;
      high_nxt       = high_upd;
      non_ascii_nxt  = non_ascii_upd;
      esc_pend_nxt   = esc_pend_upd;
      jis_nxt        = jis_upd;
      wide_nxt       = wide_upd;
      sjis_skip_nxt  = sjis_skip_upd;
      utf8_skip_nxt  = utf8_skip_upd;
      euc_skip_nxt   = euc_skip_upd;
      sjis_score_nxt = sjis_score_upd;
      utf8_score_nxt = utf8_score_upd;
      euc_score_nxt  = euc_score_upd;
    end
  end

  // capture stage: freeze what the verdict needs on the final byte
  always_comb begin
    fin_nxt = fin_r;
    if (in_acc && in_ch.last_byte) begin
      fin_nxt.bom_le     = bom_upd[0] && (byte_idx_r != 3'd0);
      fin_nxt.bom_be     = bom_upd[1] && (byte_idx_r != 3'd0);
      fin_nxt.bom_u8     = bom_upd[2] && (byte_idx_r >= 3'd2);
      fin_nxt.jis        = jis_upd;
      fin_nxt.wide       = wide_upd;
      fin_nxt.non_ascii  = non_ascii_upd;
      fin_nxt.sjis_score = sjis_score_upd;
      fin_nxt.utf8_score = utf8_score_upd;
      fin_nxt.euc_score  = euc_score_upd;
    end

    fin_valid_nxt = fin_valid_r;
    if (in_acc && in_ch.last_byte) begin
      fin_valid_nxt = 1'b1;
    end else if (fin_move) begin
      fin_valid_nxt = 1'b0;
    end
  end

  // verdict in priority order; a tie for the highest score gives unset
  always_comb begin
    enc_t v;
    if (fin_r.bom_le) begin
      v = ENC_UTF16LE;
    end else if (fin_r.bom_be) begin
      v = ENC_UTF16BE;
    end else if (fin_r.bom_u8) begin
      v = ENC_UTF8;
    end else if (fin_r.jis) begin
      v = ENC_JIS;
    end else if (fin_r.wide == WIDE_LE) begin
      v = ENC_UTF16LE;
    end else if (fin_r.wide == WIDE_BE) begin
      v = ENC_UTF16BE;
    end else if (!fin_r.non_ascii) begin
      v = ENC_ASCII;
    end else if (fin_r.sjis_score > fin_r.euc_score &&
                 fin_r.sjis_score > fin_r.utf8_score) begin
      v = ENC_SJIS;
    end else if (fin_r.utf8_score > fin_r.euc_score &&
                 fin_r.utf8_score > fin_r.sjis_score) begin
      v = ENC_UTF8;
    end else if (fin_r.euc_score > fin_r.sjis_score &&
                 fin_r.euc_score > fin_r.utf8_score) begin
      v = ENC_EUCJP;
    end else begin
      v = ENC_UNSET;
    end

    out_enc_nxt = fin_move ? v : out_enc_r;

    out_valid_nxt = out_valid_r;
    if (fin_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      byte_idx_r   <= 3'd0;
      parity_r     <= 1'b0;
      bom_r        <= 3'b111;
      high_r       <= 1'b0;
      non_ascii_r  <= 1'b0;
      esc_pend_r   <= 1'b0;
      jis_r        <= 1'b0;
      wide_r       <= WIDE_NONE;
      sjis_skip_r  <= 1'b0;
      utf8_skip_r  <= 1'b0;
      euc_skip_r   <= 2'd0;
      sjis_score_r <= '0;
      utf8_score_r <= '0;
      euc_score_r  <= '0;
      fin_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hist_r       <= hist_nxt;
      byte_idx_r   <= byte_idx_nxt;
      parity_r     <= parity_nxt;
      bom_r        <= bom_nxt;
      high_r       <= high_nxt;
      non_ascii_r  <= non_ascii_nxt;
      esc_pend_r   <= esc_pend_nxt;
      jis_r        <= jis_nxt;
      wide_r       <= wide_nxt;
      sjis_skip_r  <= sjis_skip_nxt;
      utf8_skip_r  <= utf8_skip_nxt;
      euc_skip_r   <= euc_skip_nxt;
      sjis_score_r <= sjis_score_nxt;
      utf8_score_r <= utf8_score_nxt;
      euc_score_r  <= euc_score_nxt;
      fin_valid_r  <= fin_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fin_r     <= fin_nxt;
    out_enc_r <= out_enc_nxt;
  end

  // final byte always lands in the capture stage
  `ASSERT_NEXT(a_fin_load, clk, rst_n, in_acc && in_ch.last_byte, fin_valid_r)

  // final byte clears the detector for the next buffer
  `ASSERT_NEXT(a_state_clear, clk, rst_n, in_acc && in_ch.last_byte,
               byte_idx_r == 3'd0 && bom_r == 3'b111 && sjis_score_r == '0 && !jis_r)

  // byte count holds at its ceiling on long buffers
  `ASSERT_NEXT(a_idx_sat, clk, rst_n,
               in_acc && !in_ch.last_byte && byte_idx_r == IDX_MAX, byte_idx_r == IDX_MAX)

  // a complete little-endian mark wins over every other test
  `ASSERT_NEXT(a_bom_le, clk, rst_n, fin_move && fin_r.bom_le,
               out_valid_r && out_enc_r == ENC_UTF16LE)

  // euc skip counts down from two at most
  `ASSERT_ALWAYS(a_euc_skip, clk, rst_n, euc_skip_r != 2'd3)

endmodule

@@ tb/sv/text_encoding_detector_core_tb.sv @@
// self-checking testbench of the text encoding detector: byte buffers in, verdicts checked
`timescale 1ns / 1ps

module text_encoding_detector_core_tb;
  import ted_pkg::*;

  // receiver hold-off length for the backpressure episode
  localparam int HOLD_CYCLES = 60;
  // cycles without any transaction before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // minimum random bytes per idling phase, four phases
  localparam int PHASE_BYTES = 213;

  typedef enum int {
    KIND_ASCII,
    KIND_BOM,
    KIND_JIS,
    KIND_WIDE,
    KIND_TEXT,
    KIND_NOISE
  } text_kind_t;

  // tracks the detector state per byte and queues the verdict each buffer must give
  class verdict_board;
    enc_t        expected_q[$];
    int          mismatches;
    logic [7:0]  hist [6];
    logic [2:0]  nbytes;
    logic        parity;
    logic [2:0]  marks_alive;
    logic        hi_seen;
    logic        other_seen;
    logic        esc_armed;
    logic        jis_hit;
    enc_t        wide_hit;
    logic        sjis_skip;
    logic        utf8_skip;
    logic [1:0]  euc_skip;
    logic [17:0] sjis_pts;
    logic [17:0] utf8_pts;
    logic [17:0] euc_pts;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      foreach (hist[i]) hist[i] = 8'h00;
      nbytes      = 3'd0;
      parity      = 1'b0;
      marks_alive = 3'b111;
      hi_seen     = 1'b0;
      other_seen  = 1'b0;
      esc_armed   = 1'b0;
      jis_hit     = 1'b0;
      wide_hit    = ENC_UNSET;
      sjis_skip   = 1'b0;
      utf8_skip   = 1'b0;
      euc_skip    = 2'd0;
      sjis_pts    = '0;
      utf8_pts    = '0;
      euc_pts     = '0;
    endfunction

    function bit rng(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
      return (v >= lo) && (v <= hi);
    endfunction

    function logic [17:0] bump(logic [17:0] s, int unsigned inc);
      int unsigned sum;
      sum = s + inc;
      return (sum > 18'h3FFFF) ? 18'h3FFFF : sum[17:0];
    endfunction

    function void rate_sjis(logic [7:0] a, logic [7:0] b);
      if (sjis_skip) begin
        sjis_skip = 1'b0;
        return;
      end
      if ((rng(a, 8'h81, 8'h9F) || rng(a, 8'hE0, 8'hFC)) &&
          (rng(b, 8'h40, 8'h7E) || rng(b, 8'h80, 8'hFC))) begin
        sjis_pts  = bump(sjis_pts, 2);
        sjis_skip = 1'b1;
      end
    endfunction

    // a three-byte match scores 3 but still skips a single start
    function void rate_utf8(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit has_c);
      if (utf8_skip) begin
        utf8_skip = 1'b0;
        return;
      end
      if (rng(a, 8'hC0, 8'hDF) && rng(b, 8'h80, 8'hBF)) begin
        utf8_pts  = bump(utf8_pts, 2);
        utf8_skip = 1'b1;
      end else if (has_c && rng(a, 8'hE0, 8'hEF) && rng(b, 8'h80, 8'hBF) &&
                   rng(c, 8'h80, 8'hBF)) begin
        utf8_pts  = bump(utf8_pts, 3);
        utf8_skip = 1'b1;
      end
    endfunction

    function void rate_euc(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit has_c);
      if (euc_skip != 2'd0) begin
        euc_skip = euc_skip - 2'd1;
        return;
      end
      if ((rng(a, 8'hA1, 8'hFE) && rng(b, 8'hA1, 8'hFE)) ||
          (a == 8'h8E && rng(b, 8'hA1, 8'hDF))) begin
        euc_pts  = bump(euc_pts, 2);
        euc_skip = 2'd1;
      end else if (has_c && a == 8'h8F && rng(b, 8'hA1, 8'hFE) &&
                   rng(c, 8'hA1, 8'hFE)) begin
        euc_pts  = bump(euc_pts, 3);
        euc_skip = 2'd2;
      end
    endfunction

    // newest bytes of the window complete one of the iso-2022-jp escapes
    function bit escape_tail(int count);
      bit hit;
      hit = 1'b0;
      if (count >= 3 && hist[2] == 8'h1B &&
          ((hist[1] == 8'h28 && (hist[0] == 8'h42 || hist[0] == 8'h4A || hist[0] == 8'h49)) ||
           (hist[1] == 8'h24 && (hist[0] == 8'h40 || hist[0] == 8'h42))))
        hit = 1'b1;
      if (count >= 4 && hist[3] == 8'h1B && hist[2] == 8'h24 && hist[1] == 8'h28 &&
          hist[0] == 8'h44)
        hit = 1'b1;
      if (count >= 6 && hist[5] == 8'h1B && hist[4] == 8'h26 && hist[3] == 8'h40 &&
          hist[2] == 8'h1B && hist[1] == 8'h24 && hist[0] == 8'h42)
        hit = 1'b1;
      return hit;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int         p;
      int         n;
      logic [7:0] prev1;
      logic [7:0] prev2;
      enc_t       v;
      p     = nbytes;
      prev1 = hist[0];
      prev2 = hist[1];

      // a mark survives only while every byte so far matches it
      if (p < 2 && b != ((p == 0) ? 8'hFF : 8'hFE)) marks_alive[0] = 1'b0;
      if (p < 2 && b != ((p == 0) ? 8'hFE : 8'hFF)) marks_alive[1] = 1'b0;
      if (p < 3 && b != ((p == 0) ? 8'hEF : (p == 1) ? 8'hBB : 8'hBF)) marks_alive[2] = 1'b0;

      if (esc_armed) jis_hit = 1'b1;
      if (p >= 1 && wide_hit == ENC_UNSET && prev1 == 8'h00 && b <= 8'h7F)
        wide_hit = parity ? ENC_UTF16BE : ENC_UTF16LE;
      if (b > 8'h7F) hi_seen = 1'b1;
      if (b == 8'h1B || b >= 8'h80) other_seen = 1'b1;

      if (p >= 1) rate_sjis(prev1, b);
      if (p >= 2) begin
        rate_utf8(prev2, prev1, b, 1'b1);
        rate_euc(prev2, prev1, b, 1'b1);
      end
      if (last && p >= 1) begin
        rate_utf8(prev1, b, 8'h00, 1'b0);
        rate_euc(prev1, b, 8'h00, 1'b0);
      end

      for (int i = 5; i > 0; i--) hist[i] = hist[i-1];
      hist[0]   = b;
      esc_armed = !hi_seen && escape_tail(p + 1);
      nbytes    = (p < 7) ? 3'(p + 1) : 3'd7;
      parity    = ~parity;

      if (!last) return;
      n = p + 1;
      if (marks_alive[0] && n >= 2)      v = ENC_UTF16LE;
      else if (marks_alive[1] && n >= 2) v = ENC_UTF16BE;
      else if (marks_alive[2] && n >= 3) v = ENC_UTF8;
      else if (jis_hit)                  v = ENC_JIS;
      else if (wide_hit != ENC_UNSET)    v = wide_hit;
      else if (!other_seen)              v = ENC_ASCII;
      else if (sjis_pts > euc_pts && sjis_pts > utf8_pts) v = ENC_SJIS;
      else if (utf8_pts > euc_pts && utf8_pts > sjis_pts) v = ENC_UTF8;
      else if (euc_pts > sjis_pts && euc_pts > utf8_pts)  v = ENC_EUCJP;
      else                               v = ENC_UNSET;
      expected_q = {expected_q, v};
      clear();
    endfunction

    function void check_verdict(enc_t got);
      enc_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("verdict %0d arrived with none pending", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict mismatch: expected %s (%0d), got %0d", want.name(), want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ted_in_if  in_ch();
  ted_out_if out_ch();

  text_encoding_detector_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  verdict_board board = new();

  // idling percentages of the current phase
  int         send_idle = 0;
  int         recv_stall = 0;
  // raised by the stimulus to start one long receiver hold-off
  bit         hold_req = 1'b0;
  int         quiet_cycles = 0;
  // bytes of the buffer being built
  logic [7:0] text_q[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // buffer builders
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic void push_text(logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  // printable ascii only, so plain text stays plain
  function automatic void add_ascii(int n);
    repeat (n) push_text(pick(8'h20, 8'h7E));
  endfunction

  // one well-formed multibyte character: 0 shift-jis, 1 utf-8, 2 euc-jp
  function automatic void add_jp_char(int style);
    case (style)
      0: begin
        push_text($urandom_range(1) ? pick(8'h81, 8'h9F) : pick(8'hE0, 8'hFC));
        push_text($urandom_range(1) ? pick(8'h40, 8'h7E) : pick(8'h80, 8'hFC));
      end
      1: begin
        if ($urandom_range(1)) begin
          push_text(pick(8'hC2, 8'hDF));
          push_text(pick(8'h80, 8'hBF));
        end else begin
          push_text(pick(8'hE0, 8'hEF));
          push_text(pick(8'h80, 8'hBF));
          push_text(pick(8'h80, 8'hBF));
        end
      end
      default: begin
        case ($urandom_range(2))
          0: begin
            push_text(pick(8'hA1, 8'hFE));
            push_text(pick(8'hA1, 8'hFE));
          end
          1: begin
            push_text(8'h8E);
            push_text(pick(8'hA1, 8'hDF));
          end
          default: begin
            push_text(8'h8F);
            push_text(pick(8'hA1, 8'hFE));
            push_text(pick(8'hA1, 8'hFE));
          end
        endcase
      end
    endcase
  endfunction

  function automatic void add_escape(int e);
    case (e)
      0: begin push_text(8'h1B); push_text(8'h28); push_text(8'h42); end
      1: begin push_text(8'h1B); push_text(8'h28); push_text(8'h4A); end
      2: begin push_text(8'h1B); push_text(8'h28); push_text(8'h49); end
      3: begin push_text(8'h1B); push_text(8'h24); push_text(8'h40); end
      4: begin push_text(8'h1B); push_text(8'h24); push_text(8'h42); end
      5: begin
        push_text(8'h1B); push_text(8'h26); push_text(8'h40);
        push_text(8'h1B); push_text(8'h24); push_text(8'h42);
      end
      default: begin
        push_text(8'h1B); push_text(8'h24); push_text(8'h28); push_text(8'h44);
      end
    endcase
  endfunction

  // first n bytes of mark m: 0 ff fe, 1 fe ff, 2 ef bb bf
  function automatic void add_mark(int m, int n);
    logic [7:0] mk [3];
    case (m)
      0:       begin mk[0] = 8'hFF; mk[1] = 8'hFE; mk[2] = 8'h00; end
      1:       begin mk[0] = 8'hFE; mk[1] = 8'hFF; mk[2] = 8'h00; end
      default: begin mk[0] = 8'hEF; mk[1] = 8'hBB; mk[2] = 8'hBF; end
    endcase
    for (int i = 0; i < n; i++) push_text(mk[i]);
  endfunction

  function automatic void build_text(text_kind_t kind);
    int m;
    int len;
    int style;
    bit full;
    bit be;
    logic [7:0] c;
    text_q.delete();
    case (kind)
      KIND_ASCII: add_ascii($urandom_range(12, 1));
      KIND_BOM: begin
        // full marks mostly, cut-short marks now and then
        m    = $urandom_range(2);
        len  = (m == 2) ? 3 : 2;
        full = ($urandom_range(3) != 0);
        add_mark(m, full ? len : $urandom_range(len - 1, 1));
        if (full || $urandom_range(1)) begin
          repeat ($urandom_range(3)) begin
            if ($urandom_range(1)) add_jp_char($urandom_range(2));
            else add_ascii(1);
          end
        end
      end
      KIND_JIS: begin
        add_ascii($urandom_range(3));
        // a high byte ahead of the escape disarms it
        if ($urandom_range(4) == 0) push_text(pick(8'h80, 8'hFF));
        add_escape($urandom_range(6));
        // zero bytes after the escape, with no second escape, leaves it unconfirmed
        repeat ($urandom_range(4)) push_text(pick(8'h21, 8'h7E));
        if ($urandom_range(1)) add_escape(0);
      end
      KIND_WIDE: begin
        // an odd lead byte flips which position the zeros fall on
        if ($urandom_range(1)) push_text(pick(8'h20, 8'h7E));
        be = 1'($urandom_range(1));
        repeat ($urandom_range(6, 1)) begin
          c = ($urandom_range(7) == 0) ? pick(8'h80, 8'hFF) : pick(8'h00, 8'h7F);
          if (be) begin push_text(8'h00); push_text(c); end
          else begin push_text(c); push_text(8'h00); end
        end
      end
      KIND_TEXT: begin
        style = $urandom_range(2);
        repeat ($urandom_range(6, 1)) begin
          m = $urandom_range(9);
          if (m < 6) add_jp_char(style);
          else if (m < 8) add_ascii(1);
          else add_jp_char($urandom_range(2));
        end
        // a dangling lead byte exercises the pair checks on the final byte
        if ($urandom_range(4) == 0) push_text(pick(8'h81, 8'hFE));
      end
      default: repeat ($urandom_range(16, 1)) push_text(pick(8'h00, 8'hFF));
    endcase
    if (text_q.size() == 0) add_ascii(1);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one byte per transaction, random gaps before each offer
  // ---------------------------------------------------------------------------

  task automatic put_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_byte(b, last);
  endtask

  task automatic send_text();
    foreach (text_q[i]) put_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // verdict monitor and hang watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) board.check_verdict(out_ch.encoding);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int sent;
    text_kind_t kind;
    int r;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed buffers, no idling
    // single zero byte is still plain ascii
    text_q = '{8'h00};                         send_text();
    // lone ff: mark cut short, falls through to a score tie
    text_q = '{8'hFF};                         send_text();
    text_q = '{8'hFF, 8'hFE};                  send_text();
    text_q = '{8'hFE, 8'hFF};                  send_text();
    // utf-8 mark missing its last byte: shift-jis and euc tie, so unset
    text_q = '{8'hEF, 8'hBB};                  send_text();
    text_q = '{8'hEF, 8'hBB, 8'hBF};           send_text();
    text_q = '{8'h1B, 8'h28, 8'h42, 8'h41};    send_text();
    // escape as the very last bytes does not count
    text_q = '{8'h1B, 8'h24, 8'h42};           send_text();
    text_q = '{8'h41, 8'h00, 8'h42};           send_text();
    text_q = '{8'h82, 8'hA0};                  send_text();
    // three-byte utf-8 that advances by two
    text_q = '{8'hE3, 8'h81, 8'h82};           send_text();
    text_q = '{8'h8F, 8'hA1, 8'hA1};           send_text();
    text_q = '{8'h7F, 8'h80};                  send_text();

    // backpressure: receiver holds off while one-byte buffers keep coming,
    // so both verdict stages fill and the input stalls
    hold_req = 1'b1;
    repeat (16) begin
      text_q.delete();
      push_text(pick(8'h00, 8'hFF));
      send_text();
    end

    // random buffers across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 60; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 60; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 10)      kind = KIND_ASCII;
        else if (r < 22) kind = KIND_BOM;
        else if (r < 36) kind = KIND_JIS;
        else if (r < 48) kind = KIND_WIDE;
        else if (r < 85) kind = KIND_TEXT;
        else             kind = KIND_NOISE;
        build_text(kind);
        send_text();
        sent += text_q.size();
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then give the pipeline time to show any stray verdict
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
